FILE: rtl/wqsc_pkg.sv
// shared constants, register codes and types for the windowed queue severity classifier
package wqsc_pkg;

    // default structure sizes
    localparam int MAX_WINDOW_DEF  = 2048;
    localparam int NUM_CAMERAS_DEF = 4;

    // field widths
    localparam int MASK_W       = 4;
    localparam int PEOPLE_W     = 10;
    localparam int SEV_W        = 2;
    localparam int WLEN_W       = 12;
    localparam int RATIO_W      = 9;
    localparam int RATIO_FRAC_W = 8;
    localparam int OCC_W        = 11;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RATIO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATIO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_OCCUPANCY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_OCCUPANCY  = 3'd4;

    // register reset values
    localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RST  = 12'd1800;
    localparam logic [RATIO_W-1:0] LOW_RATIO_RST      = 9'd64;
    localparam logic [RATIO_W-1:0] HIGH_RATIO_RST     = 9'd128;
    localparam logic [OCC_W-1:0]   LOW_OCCUPANCY_RST  = 11'd1024;
    localparam logic [OCC_W-1:0]   HIGH_OCCUPANCY_RST = 11'd1024;

    // severity codes
    localparam logic [SEV_W-1:0] SEV_LOW    = 2'd0;
    localparam logic [SEV_W-1:0] SEV_MEDIUM = 2'd1;
    localparam logic [SEV_W-1:0] SEV_HIGH   = 2'd2;

    // ratio flags and head count handed from the window unit to the classifier
    typedef struct packed {
        logic                below_low;
        logic                below_high;
        logic [PEOPLE_W-1:0] people;
    } wqsc_flags_t;

endpackage

FILE: rtl/wqsc_if.sv
// valid/ready channel interfaces for frame summaries and severity results
interface wqsc_frame_if;
    logic                          valid;
    logic                          ready;
    logic [wqsc_pkg::MASK_W-1:0]   queue_visible_mask;
    logic [wqsc_pkg::PEOPLE_W-1:0] people_in_room;

    modport source (output valid, output queue_visible_mask, output people_in_room,
                    input ready);
    modport sink   (input valid, input queue_visible_mask, input people_in_room,
                    output ready);
endinterface

interface wqsc_result_if;
    logic                       valid;
    logic                       ready;
    logic [wqsc_pkg::SEV_W-1:0] severity;

    modport source (output valid, output severity, input ready);
    modport sink   (input valid, input severity, output ready);
endinterface

FILE: rtl/wqsc_window.sv
// sliding window of queue bits in a memory, running count and ratio compares
module wqsc_window #(
    parameter int MAX_WINDOW  = wqsc_pkg::MAX_WINDOW_DEF,
    parameter int NUM_CAMERAS = wqsc_pkg::NUM_CAMERAS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic [wqsc_pkg::WLEN_W-1:0]      window_length,
    input  logic [wqsc_pkg::RATIO_W-1:0]     low_ratio,
    input  logic [wqsc_pkg::RATIO_W-1:0]     high_ratio,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [wqsc_pkg::MASK_W-1:0]      mask,
    input  logic [wqsc_pkg::PEOPLE_W-1:0]    people,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wqsc_pkg::wqsc_flags_t            flags
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = wqsc_pkg::RATIO_W + CW;

    // history store
    logic mem [MAX_WINDOW];
    logic rd_data_reg;

    // front stage state
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] count_reg, count_next;

    logic [CW-1:0] win;
    logic          drop;
    logic [CW-1:0] wp_ext;
    logic [AW-1:0] rd_addr;
    logic          qbit;
    logic          accept;

    // stage one
    logic                          s1_valid_reg;
    logic                          s1_bit_reg;
    logic                          s1_drop_reg;
    logic [CW-1:0]                 s1_fill_reg;
    logic [wqsc_pkg::PEOPLE_W-1:0] s1_people_reg;

    // stage two
    logic                          s2_valid_reg;
    logic [CW-1:0]                 s2_count_reg;
    logic [PW-1:0]                 s2_low_prod_reg;
    logic [PW-1:0]                 s2_high_prod_reg;
    logic [wqsc_pkg::PEOPLE_W-1:0] s2_people_reg;

    logic          s1_go, s2_go;
    logic [PW-1:0] scaled_count;

    always_comb
    begin
        if (window_length == '0)
            win = CW'(1);
        else if (32'(window_length) > 32'(MAX_WINDOW))
            win = CW'(MAX_WINDOW);
        else
            win = CW'(window_length);
    end

    always_comb
    begin
        qbit = 1'b0;
        for (int i = 0; i < wqsc_pkg::MASK_W; i++)
        begin
            if (i < NUM_CAMERAS)
                qbit = qbit | mask[i];
        end
    end

    assign drop   = (fill_reg >= win);
    assign wp_ext = CW'(wp_reg);

    // oldest entry sits fill places behind the write pointer
    always_comb
    begin
        if (wp_ext >= fill_reg)
            rd_addr = AW'(wp_ext - fill_reg);
        else
            rd_addr = AW'(wp_ext + CW'(MAX_WINDOW) - fill_reg);
    end

    assign s2_go    = !s2_valid_reg || out_ready;
    assign s1_go    = !s1_valid_reg || s2_go;
    assign in_ready = s1_go;
    assign accept   = in_valid && in_ready;

    assign wp_next   = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
    assign fill_next = drop ? fill_reg : fill_reg + CW'(1);

    // read-first: with a full-size window the oldest entry is the one overwritten
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_reg] <= qbit;
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (clear)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_go)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg    <= qbit;
            s1_drop_reg   <= drop;
            s1_fill_reg   <= fill_next;
            s1_people_reg <= people;
        end
    end

    // running count of set bits in the window
    always_comb
    begin
        count_next = count_reg + CW'(s1_bit_reg);
        if (s1_drop_reg && rd_data_reg)
            count_next = count_next - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (clear)
            count_reg <= '0;
        else if (s1_valid_reg && s2_go)
            count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_go)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_go)
        begin
            s2_count_reg     <= count_next;
            s2_low_prod_reg  <= PW'(low_ratio) * PW'(s1_fill_reg);
            s2_high_prod_reg <= PW'(high_ratio) * PW'(s1_fill_reg);
            s2_people_reg    <= s1_people_reg;
        end
    end

    // count/fill < thr/256 done as count*256 < thr*fill
    assign scaled_count = PW'({s2_count_reg, {wqsc_pkg::RATIO_FRAC_W{1'b0}}});

    assign out_valid        = s2_valid_reg;
    assign flags.below_low  = (scaled_count < s2_low_prod_reg);
    assign flags.below_high = (scaled_count < s2_high_prod_reg);
    assign flags.people     = s2_people_reg;

endmodule

FILE: rtl/windowed_queue_severity_classifier.sv
// top level: configuration registers, window unit and severity output register
//
//  channel  | dir | payload                              | transfer when
//  ---------+-----+--------------------------------------+------------------------
//  frame    | in  | queue_visible_mask, people_in_room   | frame.valid & ready
//  result   | out | severity                             | result.valid & ready
//  cfg      | in  | cfg_index, cfg_data                  | cfg_write
//
//  one frame per cycle sustained while the result is not stalled; a frame's severity is registered through
//  (history memory read, count update with threshold products, ratio compare into output reg)
//  the history memory has one write and one registered read port, both used at each transfer
//  reset empties the window; a write to window_length empties it as well
//  a stalled result holds the pipeline stages behind it, bubbles are squeezed out
module windowed_queue_severity_classifier #(
    parameter int MAX_WINDOW  = wqsc_pkg::MAX_WINDOW_DEF,
    parameter int NUM_CAMERAS = wqsc_pkg::NUM_CAMERAS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    wqsc_frame_if.sink                          frame,
    wqsc_result_if.source                       result,
    input  logic                                cfg_write,
    input  logic [wqsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wqsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [wqsc_pkg::WLEN_W-1:0]  window_length_reg;
    logic [wqsc_pkg::RATIO_W-1:0] low_ratio_reg;
    logic [wqsc_pkg::RATIO_W-1:0] high_ratio_reg;
    logic [wqsc_pkg::OCC_W-1:0]   low_occ_reg;
    logic [wqsc_pkg::OCC_W-1:0]   high_occ_reg;

    logic                         clear;
    logic                         win_valid;
    logic                         take;
    wqsc_pkg::wqsc_flags_t        flags;
    logic [wqsc_pkg::OCC_W-1:0]   people_ext;

    logic                         out_valid_reg;
    logic [wqsc_pkg::SEV_W-1:0]   severity_reg, severity_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wqsc_pkg::WINDOW_LENGTH_RST;
            low_ratio_reg     <= wqsc_pkg::LOW_RATIO_RST;
            high_ratio_reg    <= wqsc_pkg::HIGH_RATIO_RST;
            low_occ_reg       <= wqsc_pkg::LOW_OCCUPANCY_RST;
            high_occ_reg      <= wqsc_pkg::HIGH_OCCUPANCY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wqsc_pkg::CFG_WINDOW_LENGTH:
                    window_length_reg <= cfg_data[wqsc_pkg::WLEN_W-1:0];
                wqsc_pkg::CFG_LOW_RATIO:
                    low_ratio_reg <= cfg_data[wqsc_pkg::RATIO_W-1:0];
                wqsc_pkg::CFG_HIGH_RATIO:
                    high_ratio_reg <= cfg_data[wqsc_pkg::RATIO_W-1:0];
                wqsc_pkg::CFG_LOW_OCCUPANCY:
                    low_occ_reg <= cfg_data[wqsc_pkg::OCC_W-1:0];
                wqsc_pkg::CFG_HIGH_OCCUPANCY:
                    high_occ_reg <= cfg_data[wqsc_pkg::OCC_W-1:0];
                default: ;
            endcase
        end
    end

    // new window length starts an empty window
    assign clear = cfg_write && (cfg_index == wqsc_pkg::CFG_WINDOW_LENGTH);

    assign take = !out_valid_reg || result.ready;

    wqsc_window #(
        .MAX_WINDOW  (MAX_WINDOW),
        .NUM_CAMERAS (NUM_CAMERAS)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (clear),
        .window_length (window_length_reg),
        .low_ratio     (low_ratio_reg),
        .high_ratio    (high_ratio_reg),
        .in_valid      (frame.valid),
        .in_ready      (frame.ready),
        .mask          (frame.queue_visible_mask),
        .people        (frame.people_in_room),
        .out_valid     (win_valid),
        .out_ready     (take),
        .flags         (flags)
    );

    assign people_ext = wqsc_pkg::OCC_W'(flags.people);

    always_comb
    begin
        if (flags.below_low && (people_ext < low_occ_reg))
            severity_next = wqsc_pkg::SEV_LOW;
        else if (flags.below_high ||
                 ((people_ext >= low_occ_reg) && (people_ext < high_occ_reg)))
            severity_next = wqsc_pkg::SEV_MEDIUM;
        else
            severity_next = wqsc_pkg::SEV_HIGH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= win_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && win_valid)
            severity_reg <= severity_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.severity = severity_reg;

endmodule

FILE: dv/windowed_queue_severity_classifier_tb.sv
// self-checking testbench for the windowed queue severity classifier: directed table, random phases
module windowed_queue_severity_classifier_tb;
    import wqsc_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [MASK_W-1:0] CAMERA_MASK = MASK_W'((1 << NUM_CAMERAS_DEF) - 1);

    typedef enum logic { ROW_FRAME, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [MASK_W-1:0]     mask;
        logic [PEOPLE_W-1:0]   people;
        bit                    sev_known;
        logic [SEV_W-1:0]      sev;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wqsc_frame_if  frame_ch ();
    wqsc_result_if result_ch ();

    windowed_queue_severity_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted window state and register copies
    bit               window_bits [MAX_WINDOW_DEF];
    int               wr_ptr;
    int               window_fill;
    int               set_count;
    logic [WLEN_W-1:0]  cfg_window;
    logic [RATIO_W-1:0] cfg_low_ratio;
    logic [RATIO_W-1:0] cfg_high_ratio;
    logic [OCC_W-1:0]   cfg_low_occ;
    logic [OCC_W-1:0]   cfg_high_occ;

    logic [SEV_W-1:0] expected_severity [$];
    int  severity_errors = 0;
    int  sender_idle_pct = 0;
    int  receiver_idle_pct = 0;
    bit  hold_request = 1'b0;
    directed_row_t directed_rows [$];

    function automatic logic [SEV_W-1:0] classify_frame(logic [MASK_W-1:0] mask,
                                                        logic [PEOPLE_W-1:0] people);
        int span;
        int oldest;
        bit seen;
        bit under_low;
        bit under_high;
        span = int'(cfg_window);
        if (span == 0)
            span = 1;
        if (span > MAX_WINDOW_DEF)
            span = MAX_WINDOW_DEF;
        seen = |(mask & CAMERA_MASK);
        if (window_fill >= span)
        begin
            oldest = (wr_ptr + MAX_WINDOW_DEF - window_fill) % MAX_WINDOW_DEF;
            set_count -= window_bits[oldest];
            window_fill--;
        end
        window_bits[wr_ptr] = seen;
        wr_ptr = (wr_ptr + 1) % MAX_WINDOW_DEF;
        window_fill++;
        set_count += seen;
        // ratio compare by cross-multiplication
        under_low  = set_count * 256 < int'(cfg_low_ratio) * window_fill;
        under_high = set_count * 256 < int'(cfg_high_ratio) * window_fill;
        if (under_low && int'(people) < int'(cfg_low_occ))
            return SEV_LOW;
        if (under_high || (int'(people) >= int'(cfg_low_occ) &&
                           int'(people) < int'(cfg_high_occ)))
            return SEV_MEDIUM;
        return SEV_HIGH;
    endfunction

    function automatic void note_register(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_WINDOW_LENGTH:
            begin
                cfg_window  = value[WLEN_W-1:0];
                wr_ptr      = 0;
                window_fill = 0;
                set_count   = 0;
            end
            CFG_LOW_RATIO:      cfg_low_ratio  = value[RATIO_W-1:0];
            CFG_HIGH_RATIO:     cfg_high_ratio = value[RATIO_W-1:0];
            CFG_LOW_OCCUPANCY:  cfg_low_occ    = value[OCC_W-1:0];
            CFG_HIGH_OCCUPANCY: cfg_high_occ   = value[OCC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ratio(int centre);
        int r;
        case ($urandom_range(0, 5))
            0: r = 0;
            1: r = 256;
            2: r = 511;
            3: r = $urandom_range(0, 511);
            default: r = centre + int'($urandom_range(0, 16)) - 8;
        endcase
        if (r < 0)
            r = 0;
        if (r > 511)
            r = 511;
        return CFG_DATA_W'(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_occupancy();
        case ($urandom_range(0, 4))
            0: return CFG_DATA_W'(0);
            1: return CFG_DATA_W'(1024);
            2: return CFG_DATA_W'(2047);
            default: return CFG_DATA_W'($urandom_range(0, 1100));
        endcase
    endfunction

    // called at a rising edge; leaves valid high after the transfer
    task automatic offer_frame(input logic [MASK_W-1:0] mask, input logic [PEOPLE_W-1:0] people,
                               input bit sev_known, input logic [SEV_W-1:0] sev_given);
        logic [SEV_W-1:0] sev_pred;
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        frame_ch.valid              <= 1'b1;
        frame_ch.queue_visible_mask <= mask;
        frame_ch.people_in_room     <= people;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        sev_pred = classify_frame(mask, people);
        expected_severity.insert(expected_severity.size(), sev_known ? sev_given : sev_pred);
    endtask

    // only once the pipeline has drained
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        frame_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_severity.size() != 0);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        note_register(idx, value);
    endtask

    task automatic run_phase(input int frames, input int set_pct);
        logic [MASK_W-1:0] mask;
        int people;
        for (int k = 0; k < frames; k++)
        begin
            mask = ($urandom_range(0, 99) < set_pct) ? MASK_W'($urandom_range(1, 15)) : '0;
            if ($urandom_range(0, 1) == 0)
                people = $urandom_range(0, 1023);
            else
            begin
                // cluster around the occupancy boundaries
                people = ($urandom_range(0, 1) == 0 ? int'(cfg_low_occ) : int'(cfg_high_occ))
                         + int'($urandom_range(0, 6)) - 3;
                if (people < 0)
                    people = 0;
                if (people > 1023)
                    people = 1023;
            end
            offer_frame(mask, PEOPLE_W'(people), 1'b0, SEV_LOW);
        end
    endtask

    // result side: random stalls, one long hold-off on request, and the compare
    initial
    begin : result_drain
        int stall_left;
        int hold_left;
        logic [SEV_W-1:0] want;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_severity.size() == 0)
                begin
                    severity_errors++;
                    if (severity_errors <= 10)
                        $display("severity %0d transferred with nothing pending",
                                 result_ch.severity);
                end
                else
                begin
                    want = expected_severity[0];
                    expected_severity.delete(0);
                    if (result_ch.severity !== want)
                    begin
                        severity_errors++;
                        if (severity_errors <= 10)
                            $display("severity wrong: expected %0d, got %0d",
                                     want, result_ch.severity);
                    end
                end
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (receiver_idle_pct != 0 && $urandom_range(0, 99) < receiver_idle_pct)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int set_pct;
        int wlen;
        int idle_choice [3];
        idle_choice = '{0, 15, 40};
        rst_n                       = 1'b0;
        frame_ch.valid              = 1'b0;
        frame_ch.queue_visible_mask = '0;
        frame_ch.people_in_room     = '0;
        cfg_write                   = 1'b0;
        cfg_index                   = CFG_WINDOW_LENGTH;
        cfg_data                    = '0;
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
            window_bits[i] = 1'b0;
        wr_ptr         = 0;
        window_fill    = 0;
        set_count      = 0;
        cfg_window     = WINDOW_LENGTH_RST;
        cfg_low_ratio  = LOW_RATIO_RST;
        cfg_high_ratio = HIGH_RATIO_RST;
        cfg_low_occ    = LOW_OCCUPANCY_RST;
        cfg_high_occ   = HIGH_OCCUPANCY_RST;

        directed_rows = '{
            // reset settings
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd0,    1'b1, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'hF, 10'd1023, 1'b1, SEV_HIGH},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h8, 10'd512,  1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd1023, 1'b0, SEV_LOW},
            // one-frame window, ratio thresholds at exactly 1.0
            '{ROW_CFG,   CFG_WINDOW_LENGTH,  12'd1,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_LOW_RATIO,      12'h100,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_HIGH_RATIO,     12'h100,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd1023, 1'b1, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h1, 10'd0,    1'b1, SEV_HIGH},
            // thresholds above 1.0: a full ratio still counts as below; upper data bits dropped
            '{ROW_CFG,   CFG_LOW_RATIO,      12'h1FF,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_HIGH_RATIO,     12'hFFF,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h2, 10'd0,    1'b1, SEV_LOW},
            '{ROW_CFG,   CFG_LOW_OCCUPANCY,  12'd0,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd0,    1'b1, SEV_MEDIUM},
            '{ROW_CFG,   CFG_LOW_RATIO,      12'd0,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_HIGH_RATIO,     12'd0,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd1023, 1'b1, SEV_MEDIUM},
            '{ROW_CFG,   CFG_HIGH_OCCUPANCY, 12'd0,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h4, 10'd1023, 1'b1, SEV_HIGH},
            '{ROW_CFG,   CFG_LOW_OCCUPANCY,  12'h7FF,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_HIGH_OCCUPANCY, 12'hFFF,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'hF, 10'd1023, 1'b1, SEV_HIGH},
            // back to reset thresholds, zero window length acts as one
            '{ROW_CFG,   CFG_LOW_RATIO,      12'd64,   4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_HIGH_RATIO,     12'd128,  4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_LOW_OCCUPANCY,  12'd1024, 4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_HIGH_OCCUPANCY, 12'd1024, 4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_CFG,   CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h1, 10'd5,    1'b1, SEV_HIGH},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd5,    1'b1, SEV_LOW},
            // short window that wraps
            '{ROW_CFG,   CFG_WINDOW_LENGTH,  12'd4,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h1, 10'd7,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd300,  1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd1000, 1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h9, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd0,    1'b0, SEV_LOW},
            '{ROW_FRAME, CFG_WINDOW_LENGTH,  12'd0,    4'h0, 10'd1023, 1'b0, SEV_LOW}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 20;
        receiver_idle_pct = 20;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                offer_frame(directed_rows[i].mask, directed_rows[i].people,
                            directed_rows[i].sev_known, directed_rows[i].sev);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            set_pct = $urandom_range(0, 100);
            if (ph == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: wlen = 1;
                    1: wlen = 2;
                    2: wlen = $urandom_range(3, 16);
                    3: wlen = $urandom_range(17, 64);
                    4: wlen = 0;
                    default: wlen = $urandom_range(65, 300);
                endcase
                write_register(CFG_WINDOW_LENGTH, CFG_DATA_W'(wlen));
            end
            if (ph == 0 || $urandom_range(0, 2) != 0)
                write_register(CFG_LOW_RATIO, pick_ratio(set_pct * 256 / 100));
            if (ph == 0 || $urandom_range(0, 2) != 0)
                write_register(CFG_HIGH_RATIO, pick_ratio(set_pct * 256 / 100));
            if (ph == 0 || $urandom_range(0, 2) != 0)
                write_register(CFG_LOW_OCCUPANCY, pick_occupancy());
            if (ph == 0 || $urandom_range(0, 2) != 0)
                write_register(CFG_HIGH_OCCUPANCY, pick_occupancy());
            sender_idle_pct   = idle_choice[$urandom_range(0, 2)];
            receiver_idle_pct = idle_choice[$urandom_range(0, 2)];
            if (ph == 3)
            begin
                // sink holds off while frames keep coming, so the input backs up
                sender_idle_pct = 0;
                hold_request    = 1'b1;
            end
            run_phase(50, set_pct);
        end

        // oversized length saturates to the largest window
        write_register(CFG_WINDOW_LENGTH, 12'hFFF);
        write_register(CFG_LOW_RATIO, 12'd77);
        write_register(CFG_HIGH_RATIO, 12'd80);
        write_register(CFG_LOW_OCCUPANCY, 12'd1024);
        write_register(CFG_HIGH_OCCUPANCY, 12'd1024);
        sender_idle_pct   = 10;
        receiver_idle_pct = 10;
        run_phase(40, 30);

        // closing stretch at full rate
        set_pct = $urandom_range(0, 100);
        write_register(CFG_WINDOW_LENGTH, 12'd5);
        write_register(CFG_LOW_RATIO, pick_ratio(set_pct * 256 / 100));
        write_register(CFG_HIGH_RATIO, pick_ratio(set_pct * 256 / 100));
        write_register(CFG_LOW_OCCUPANCY, pick_occupancy());
        write_register(CFG_HIGH_OCCUPANCY, pick_occupancy());
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_phase(60, set_pct);

        frame_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_severity.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (severity_errors == 0 && expected_severity.size() == 0)
            $display("windowed_queue_severity_classifier: match");
        else
            $display("windowed_queue_severity_classifier: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("windowed_queue_severity_classifier: mismatch");
        $finish;
    end

endmodule

FILE: windowed_queue_severity_classifier.f
rtl/wqsc_pkg.sv
rtl/wqsc_if.sv
rtl/wqsc_window.sv
rtl/windowed_queue_severity_classifier.sv
dv/windowed_queue_severity_classifier_tb.sv
